// File: rtl/buzzer_alarm_pattern_generator_macros.svh
// Assertion macros used by the buzzer alarm pattern generator checker.
`ifndef BUZZER_ALARM_PATTERN_GENERATOR_MACROS_SVH
`define BUZZER_ALARM_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, switched off in reset.
`define BAPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bapg check failed");

// Next-cycle implication, sampled on the rising edge, switched off in reset.
`define BAPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bapg check failed");

`endif

// File: rtl/bapg_pkg.sv
// Types and constants of the buzzer alarm pattern generator.
`default_nettype none
package bapg_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
  localparam logic [KindW-1:0] KIND_STARTUP = 3'd1;
  localparam logic [KindW-1:0] KIND_SENSOR  = 3'd2;
  localparam logic [KindW-1:0] KIND_PUMP    = 3'd3;
  localparam logic [KindW-1:0] KIND_BATTERY = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_STARTUP_BEEP = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAST_TOGGLE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOW_ON      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOW_OFF     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_SHORT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_GAP   = 3'd5;

  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] STEP_0 = 2'd0;
  localparam logic [1:0] STEP_1 = 2'd1;
  localparam logic [1:0] STEP_2 = 2'd2;
  localparam logic [1:0] STEP_3 = 2'd3;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KindW-1:0] alarm_kind;
  } bapg_in_t;

  typedef struct packed {
    logic             buzzer_on;
    logic [KindW-1:0] active_kind;
    logic             alarm_active;
  } bapg_out_t;

  typedef struct packed {
    logic [CountW-1:0] startup_beep_ticks;
    logic [CountW-1:0] fast_toggle_ticks;
    logic [CountW-1:0] slow_on_ticks;
    logic [CountW-1:0] slow_off_ticks;
    logic [CountW-1:0] double_short_ticks;
    logic [CountW-1:0] double_gap_ticks;
  } bapg_cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic              level;
    logic [CountW-1:0] count;
    logic [1:0]        step;
  } bapg_state_t;

endpackage
`default_nettype wire

// File: rtl/bapg_step.sv
// Next-state logic of the alarm patterns for one input item.
`default_nettype none
module bapg_step
  import bapg_pkg::*;
(
  input  bapg_in_t    item,
  input  bapg_cfg_t   cfg,
  input  bapg_state_t cur,
  output bapg_state_t nxt
);

  logic [CountW-1:0] elapsed;

  assign elapsed = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'd1;

  always_comb begin
    nxt = cur;
    case (item.operation)
      OP_TICK: begin
        nxt.count = elapsed;
        case (cur.kind)
          KIND_STARTUP: begin
            if (cur.step == STEP_0 && elapsed >= cfg.startup_beep_ticks) begin
              nxt.level = 1'b0;
              nxt.count = '0;
              nxt.step  = STEP_1;
            end else if (cur.step == STEP_1) begin
              nxt.kind = KIND_NONE;
            end
          end
          KIND_SENSOR: begin
            if (elapsed >= cfg.fast_toggle_ticks) begin
              nxt.level = ~cur.level;
              nxt.count = '0;
            end
          end
          KIND_PUMP: begin
            if (cur.level && elapsed >= cfg.slow_on_ticks) begin
              nxt.level = 1'b0;
              nxt.count = '0;
            end else if (!cur.level && elapsed >= cfg.slow_off_ticks) begin
              nxt.level = 1'b1;
              nxt.count = '0;
            end
          end
          KIND_BATTERY: begin
            // Two short beeps with a short gap, then the long silent gap.
            if (cur.step == STEP_0 && elapsed >= cfg.double_short_ticks) begin
              nxt.level = 1'b0;
              nxt.count = '0;
              nxt.step  = STEP_1;
            end else if (cur.step == STEP_1 && elapsed >= cfg.double_short_ticks) begin
              nxt.level = 1'b1;
              nxt.count = '0;
              nxt.step  = STEP_2;
            end else if (cur.step == STEP_2 && elapsed >= cfg.double_short_ticks) begin
              nxt.level = 1'b0;
              nxt.count = '0;
              nxt.step  = STEP_3;
            end else if (cur.step == STEP_3 && elapsed >= cfg.double_gap_ticks) begin
              nxt.level = 1'b1;
              nxt.count = '0;
              nxt.step  = STEP_0;
            end
          end
          default: begin
            nxt.level = 1'b0;
          end
        endcase
      end
      OP_TRIGGER: begin
        if (item.alarm_kind <= KIND_BATTERY && item.alarm_kind != cur.kind) begin
          nxt.kind  = item.alarm_kind;
          nxt.count = '0;
          nxt.step  = STEP_0;
          nxt.level = (item.alarm_kind != KIND_NONE);
        end
      end
      OP_CLEAR: begin
        // The counter and step are left alone; the next trigger of an alarm kind resets them.
        if (cur.kind != KIND_NONE) begin
          nxt.kind  = KIND_NONE;
          nxt.level = 1'b0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/buzzer_alarm_pattern_generator.sv
// Top level of the buzzer alarm pattern generator.
// The block takes one beat per clock cycle (a tick, a trigger or a clear) and
// returns one result beat for each, holding the buzzer level and the alarm
// kind that stand after that item. The result is presented in the cycle after
// acceptance, or later when it has to wait in the skid register behind a
// stalled beat. The pattern state is updated by a single pass of compare and
// counter logic, so a new item can enter every cycle; the result side has an
// output register and a one-beat skid register, so input is stalled only when
// both are full. Timing registers are written through the configuration port
// only while idle: a rule for the user, which the block does not enforce.
`default_nettype none
module buzzer_alarm_pattern_generator
  import bapg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bapg_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bapg_out_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_wdata
);

  bapg_cfg_t   cfg;
  bapg_state_t state;
  bapg_state_t state_next;
  bapg_out_t   result;
  bapg_out_t   skid_data;
  logic        skid_valid;
  logic        in_accept;
  logic        out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  bapg_step u_step (
    .item (in_data),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next)
  );

  assign result.buzzer_on    = state_next.level;
  assign result.active_kind  = state_next.kind;
  assign result.alarm_active = (state_next.kind != KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_beep_ticks <= 16'd150;
      cfg.fast_toggle_ticks  <= 16'd150;
      cfg.slow_on_ticks      <= 16'd1000;
      cfg.slow_off_ticks     <= 16'd500;
      cfg.double_short_ticks <= 16'd100;
      cfg.double_gap_ticks   <= 16'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STARTUP_BEEP: cfg.startup_beep_ticks <= cfg_wdata;
        REG_FAST_TOGGLE:  cfg.fast_toggle_ticks  <= cfg_wdata;
        REG_SLOW_ON:      cfg.slow_on_ticks      <= cfg_wdata;
        REG_SLOW_OFF:     cfg.slow_off_ticks     <= cfg_wdata;
        REG_DOUBLE_SHORT: cfg.double_short_ticks <= cfg_wdata;
        REG_DOUBLE_GAP:   cfg.double_gap_ticks   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // A beat waiting in the skid register always goes out before a new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bapg_checker.sv
// Port-level assertions for the buzzer alarm pattern generator, with its bind.
`default_nettype none
`include "buzzer_alarm_pattern_generator_macros.svh"
module bapg_checker
  import bapg_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input bapg_out_t          out_data
);

  `BAPG_ASSERT_NOW(a_active_flag, out_valid, out_data.alarm_active == (out_data.active_kind != KIND_NONE))
  `BAPG_ASSERT_NOW(a_silent_when_idle, out_valid && !out_data.alarm_active, !out_data.buzzer_on)
  `BAPG_ASSERT_NOW(a_kind_range, out_valid, out_data.active_kind <= KIND_BATTERY)
  `BAPG_ASSERT_NEXT(a_stalled_beat_holds, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind buzzer_alarm_pattern_generator bapg_checker u_bapg_checker (.*);
`default_nettype wire
